// ===== hdl/ccc_pkg.sv =====
// shared types and constants for the convolution / correlation engine
// used by ccc_cell, ccc_scale and convolution_correlation_engine_core
package ccc_pkg;

   localparam int MAX_KERNEL_DEF = 32;
   localparam int SAMPLE_W       = 16;
   localparam int KIND_W         = 2;
   localparam int PROD_W         = 32;
   localparam int FULL_SCALE     = 32767;
   // smallest magnitude whose quotient by full scale exceeds full scale
   localparam int SAT_LIMIT      = 32768 * 32767;
   localparam int MAG_W          = 30;
   localparam int QSHIFT         = 15;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD  = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_FLUSH = 2'd2
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_COMPUTE
   } state_type;

   typedef struct packed {
      logic data_shift;
      logic data_clear;
      logic kern_load;
      logic mode;
   } cell_ctrl_type;

endpackage

// ===== hdl/ccc_cell.sv =====
// one tap cell: delay entry, forward and reversed kernel entry, product and
// a running partial sum handed to the next cell; depends on ccc_pkg
module ccc_cell import ccc_pkg::*; #(
   parameter int IDX    = 0,
   parameter int KLEN_W = 6,
   parameter int ACC_W  = 37
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctrl_type              ctrl,
   input  logic [KLEN_W-1:0]          wr_idx,
   input  logic [KLEN_W-1:0]          klen,
   input  logic signed [SAMPLE_W-1:0] d_prev,
   input  logic signed [SAMPLE_W-1:0] hr_prev,
   input  logic signed [SAMPLE_W-1:0] kern_sample,
   input  logic signed [ACC_W-1:0]    sum_prev,
   output logic signed [SAMPLE_W-1:0] d_out,
   output logic signed [SAMPLE_W-1:0] hr_out,
   output logic signed [ACC_W-1:0]    sum_out
);

   logic signed [SAMPLE_W-1:0] d_ff, hf_ff, hr_ff;
   logic signed [SAMPLE_W-1:0] coef;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    sum_ff, sum_in;
   logic                       active;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else if (ctrl.data_clear) begin
         d_ff <= '0;
      end else if (ctrl.data_shift) begin
         d_ff <= d_prev;
      end
   end

   // forward copy is written by address, reversed copy shifts in at cell 0
   always_ff @(posedge clock) begin
      if (ctrl.kern_load && (wr_idx == KLEN_W'(IDX))) begin
         hf_ff <= kern_sample;
      end
      if (ctrl.kern_load) begin
         hr_ff <= hr_prev;
      end
   end

   assign active  = (klen > KLEN_W'(IDX));
   assign coef    = ctrl.mode ? hr_ff : hf_ff;
   assign prod_in = active ? (PROD_W'(coef) * PROD_W'(d_ff)) : '0;
   assign sum_in  = sum_prev + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign d_out   = d_ff;
   assign hr_out  = hr_ff;
   assign sum_out = sum_ff;

endmodule

// ===== hdl/ccc_scale.sv =====
// divides the tap sum by full scale toward zero and saturates, two stages
// depends on ccc_pkg
module ccc_scale import ccc_pkg::*; #(
   parameter int ACC_W = 37
) (
   input  logic                       clock,
   input  logic signed [ACC_W-1:0]    acc_in,
   output logic signed [SAMPLE_W-1:0] value_out
);

   logic [ACC_W-1:0]           mag;
   logic                       neg_ff, sat_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic [MAG_W-1:0]           qsum;
   logic [SAMPLE_W-1:0]        mq;
   logic signed [SAMPLE_W-1:0] value_in, value_ff;

   assign mag = acc_in[ACC_W-1] ? (-acc_in) : acc_in;

   always_ff @(posedge clock) begin
      neg_ff <= acc_in[ACC_W-1];
      sat_ff <= (mag >= ACC_W'(SAT_LIMIT));
      mag_ff <= mag[MAG_W-1:0];
   end

   // x / (2^15 - 1) == (x + (x >> 15) + 1) >> 15 while the quotient fits 15 bits
   assign qsum     = mag_ff + (mag_ff >> QSHIFT) + MAG_W'(1);
   assign mq       = sat_ff ? SAMPLE_W'(FULL_SCALE) : {1'b0, qsum[MAG_W-1:QSHIFT]};
   assign value_in = neg_ff ? (-mq) : mq;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

// ===== hdl/convolution_correlation_engine_core.sv =====
// a data item's result is loaded into the output register once the partial sum has
//   rippled through the tap chain and the scaling stage, and no new request is taken before
//   then; a held output stalls the load; flush tail outputs follow one another the same way
// kernel samples, flushes with no tail and unused kinds complete in the idle state
// reset (synchronous): empty kernel, zeroed delay line, mode convolution
// top level: controller, tap cell chain, scaling stage; depends on ccc_pkg
module convolution_correlation_engine_core import ccc_pkg::*; #(
   parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_value,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);

   localparam int KLEN_W = $clog2(MAX_KERNEL + 1);
   localparam int ACC_W  = PROD_W + $clog2(MAX_KERNEL);
   localparam int SETTLE = MAX_KERNEL + 3;
   localparam int CNT_W  = $clog2(SETTLE + 1);

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [KLEN_W-1:0]          tail_ff, tail_in;
   logic [KLEN_W-1:0]          klen_ff, klen_in;
   logic                       loadflag_ff, loadflag_in;
   logic                       mode_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_value_ff;
   logic                       rsp_last_ff;
   logic                       rsp_load;

   logic                       accept, out_free, done, kern_full;
   kind_type                   kind;
   cell_ctrl_type              ctrl;
   logic [KLEN_W-1:0]          wr_idx;
   logic signed [SAMPLE_W-1:0] data_in;
   logic signed [SAMPLE_W-1:0] scaled;

   logic signed [SAMPLE_W-1:0] d_chain  [0:MAX_KERNEL];
   logic signed [SAMPLE_W-1:0] hr_chain [0:MAX_KERNEL];
   logic signed [ACC_W-1:0]    sum_chain[0:MAX_KERNEL];

   assign kind      = kind_type'(req_kind);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign done      = (state_ff == ST_COMPUTE) && (cnt_ff == CNT_W'(SETTLE));
   assign kern_full = loadflag_ff && (klen_ff == KLEN_W'(MAX_KERNEL));
   assign wr_idx    = loadflag_ff ? klen_ff : '0;

   // next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tail_in      = tail_ff;
      klen_in      = klen_ff;
      loadflag_in  = loadflag_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  KIND_LOAD: begin
                     loadflag_in = 1'b1;
                     if (!loadflag_ff) begin
                        klen_in = KLEN_W'(1);
                     end else if (!kern_full) begin
                        klen_in = klen_ff + KLEN_W'(1);
                     end
                  end
                  KIND_DATA: begin
                     loadflag_in = 1'b0;
                     state_in    = ST_COMPUTE;
                     cnt_in      = '0;
                     tail_in     = '0;
                  end
                  KIND_FLUSH: begin
                     loadflag_in = 1'b0;
                     if (klen_ff > KLEN_W'(1)) begin
                        state_in = ST_COMPUTE;
                        cnt_in   = '0;
                        tail_in  = klen_ff - KLEN_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COMPUTE: begin
            if (!done) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (tail_ff > KLEN_W'(1)) begin
                  tail_in = tail_ff - KLEN_W'(1);
                  cnt_in  = '0;
               end else begin
                  tail_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and cell control
   always_comb begin
      req_ready       = 1'b0;
      ctrl            = '0;
      ctrl.mode       = mode_ff;
      data_in         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (kind)
                  KIND_LOAD: begin
                     ctrl.kern_load  = !kern_full;
                     ctrl.data_clear = !loadflag_ff;
                  end
                  KIND_DATA: begin
                     ctrl.data_shift = 1'b1;
                     data_in         = req_sample;
                  end
                  KIND_FLUSH: begin
                     if (klen_ff > KLEN_W'(1)) begin
                        ctrl.data_shift = 1'b1;
                     end else begin
                        ctrl.data_clear = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COMPUTE: begin
            // tail: shift a zero for the next output, clear after the last one
            if (done && out_free) begin
               if (tail_ff > KLEN_W'(1)) begin
                  ctrl.data_shift = 1'b1;
               end else if (tail_ff == KLEN_W'(1)) begin
                  ctrl.data_clear = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tail_ff      <= '0;
         klen_ff      <= '0;
         loadflag_ff  <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tail_ff      <= tail_in;
         klen_ff      <= klen_in;
         loadflag_ff  <= loadflag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= scaled;
         rsp_last_ff  <= (tail_ff == KLEN_W'(1));
      end
   end

   assign d_chain[0]   = data_in;
   assign hr_chain[0]  = req_sample;
   assign sum_chain[0] = '0;

   for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_tap
      ccc_cell #(
         .IDX    (i),
         .KLEN_W (KLEN_W),
         .ACC_W  (ACC_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .wr_idx      (wr_idx),
         .klen        (klen_ff),
         .d_prev      (d_chain[i]),
         .hr_prev     (hr_chain[i]),
         .kern_sample (req_sample),
         .sum_prev    (sum_chain[i]),
         .d_out       (d_chain[i+1]),
         .hr_out      (hr_chain[i+1]),
         .sum_out     (sum_chain[i+1])
      );
   end

   ccc_scale #(
      .ACC_W (ACC_W)
   ) u_scale (
      .clock     (clock),
      .acc_in    (sum_chain[MAX_KERNEL]),
      .value_out (scaled)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

   a_klen_range: assert property (@(posedge clock) disable iff (reset)
      klen_ff <= KLEN_W'(MAX_KERNEL))
      else $error("kernel length beyond capacity");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SETTLE))
      else $error("settle counter overran");

   a_tail_range: assert property (@(posedge clock) disable iff (reset)
      (tail_ff == '0) || (tail_ff < klen_ff))
      else $error("tail count exceeds kernel length");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (done && out_free && (tail_ff == KLEN_W'(1)))
      |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("final tail output not marked or flush not finished");

endmodule
